// ----- rtl/miller_rabin_round_unit_defines.svh -----
// assertion macros for the miller-rabin round unit
`ifndef MILLER_RABIN_ROUND_UNIT_DEFINES_SVH
`define MILLER_RABIN_ROUND_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define MR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mrr_pkg.sv -----
`default_nettype none
package mrr_pkg;
  localparam int unsigned N_BITS_DEF = 32;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SHIFT  = 3'd2,
    OP_REDUCE = 3'd3,
    OP_MUL    = 3'd4,
    OP_DSHIFT = 3'd5,
    OP_COPY   = 3'd6
  } mrr_op_t;

  // multiply operand selection
  typedef enum logic [1:0] {
    MSEL_R_B = 2'd0,
    MSEL_B_B = 2'd1,
    MSEL_X_X = 2'd2
  } mrr_msel_t;

  typedef struct packed {
    mrr_op_t   op;
    mrr_msel_t msel;
    logic      start;
  } mrr_cmd_t;

  typedef struct packed {
    logic busy;
    logic trivial;
    logic trivial_pass;
    logic d_odd;
    logic e_zero;
    logic e_lsb;
    logic s_le1;
    logic x_one;
    logic x_nm1;
  } mrr_stat_t;
endpackage
`default_nettype wire

// ----- rtl/miller_rabin_round_unit.sv -----
`default_nettype none
// One Miller-Rabin round per request: candidate and base in, a one-bit verdict out.
// Small and even candidates skip the arithmetic. Odd candidates first reduce the base
// modulo the candidate, then run one or two shift-and-add modular multiplies per
// exponent bit and one per squaring, all on the single shared multiplier. One
// request is worked at a time; the verdict sits in an output register.
module miller_rabin_round_unit #(
  parameter int unsigned N_BITS = mrr_pkg::N_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [mrr_pkg::IN_DATA_W-1:0]  in_tdata,  // candidate, witness_base
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [mrr_pkg::OUT_DATA_W-1:0]   out_tdata   // verdict, zero fill
);
  import mrr_pkg::*;
  `include "miller_rabin_round_unit_defines.svh"

  mrr_cmd_t  cmd;
  mrr_stat_t stat;
  logic idle, done, pass, in_fire, out_free;
  logic       vld_r;
  logic [OUT_DATA_W-1:0] dat_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = !vld_r || out_tready;

  mrr_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .stat, .cmd, .idle, .done, .pass
  );

  mrr_datapath #(.N_BITS(N_BITS)) u_dp (
    .clk, .cand(in_tdata[FIELD_W-1:0]), .base(in_tdata[2*FIELD_W-1:FIELD_W]),
    .cmd, .stat
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (done && out_free) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
    if (done && out_free) dat_r <= {{(OUT_DATA_W-1){1'b0}}, pass};
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;

  `MR_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_fire, !done, "accept while result pending")
  `MR_ASSERT_NEXT(a_fire_leaves_idle, clk, rst_n, in_fire, !idle, "request did not start")
  `MR_ASSERT_IMPL(a_stall_hold, clk, rst_n, out_tvalid && !out_tready && done, !out_free,
                  "result overwrite")
endmodule
`default_nettype wire

// ----- rtl/mrr_datapath.sv -----
`default_nettype none
module mrr_datapath #(
  parameter int unsigned N_BITS = mrr_pkg::N_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [mrr_pkg::FIELD_W-1:0] cand,
  input  wire logic [mrr_pkg::FIELD_W-1:0] base,
  input  wire mrr_pkg::mrr_cmd_t       cmd,
  output mrr_pkg::mrr_stat_t           stat
);
  import mrr_pkg::*;
  localparam int unsigned SW = $clog2(N_BITS + 1);

  logic [N_BITS-1:0] n_r, d_r, b_r, r_r, x_r, nm1;
  logic [N_BITS-1:0] acc_r, ma_r, mb_r;
  logic [N_BITS-1:0] rem_r;
  logic [SW-1:0]     s_r, cnt_r;
  logic              busy_r;
  mrr_msel_t         msel_r;
  mrr_op_t           run_r;
  logic [N_BITS-1:0] n_in, b_in;
  logic [N_BITS:0]   rdbl;
  logic [N_BITS-1:0] rem_nxt, acc_nxt;

  assign n_in = N_BITS'(cand);
  assign b_in = N_BITS'(base);
  assign nm1  = n_r - N_BITS'(1);

  // modular add in one step: values stay below n
  function automatic logic [N_BITS-1:0] addm(logic [N_BITS-1:0] a, logic [N_BITS-1:0] b,
                                             logic [N_BITS-1:0] m);
    logic [N_BITS:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) addm = N_BITS'(t - {1'b0, m});
    else addm = t[N_BITS-1:0];
  endfunction

  assign rdbl    = {rem_r, b_r[N_BITS-1]};
  assign rem_nxt = (rdbl >= {1'b0, n_r}) ? N_BITS'(rdbl - {1'b0, n_r}) : rdbl[N_BITS-1:0];
  assign acc_nxt = mb_r[0] ? addm(acc_r, ma_r, n_r) : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      n_r <= n_in;
      b_r <= b_in;
      d_r <= n_in - N_BITS'(1);
      s_r <= '0;
      x_r <= '0;
      busy_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= SW'(N_BITS);
      msel_r <= cmd.msel;
      run_r  <= cmd.op;
      if (cmd.op == OP_REDUCE) begin
        rem_r <= '0;
        r_r   <= (n_r == N_BITS'(1)) ? '0 : N_BITS'(1);
      end else begin
        acc_r <= '0;
        // each squaring of x uses up one of the s-1 allowed rounds
        if (cmd.msel == MSEL_X_X) s_r <= s_r - SW'(1);
        case (cmd.msel)
          MSEL_R_B: begin ma_r <= b_r; mb_r <= r_r; end
          MSEL_B_B: begin ma_r <= b_r; mb_r <= b_r; end
          default:  begin ma_r <= x_r; mb_r <= x_r; end
        endcase
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - SW'(1);
      if (run_r == OP_REDUCE) begin
        // restoring remainder, one base bit a cycle
        rem_r <= rem_nxt;
        if (cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          b_r <= rem_nxt;
        end else b_r <= b_r << 1;
      end else begin
        // shift-and-add modular multiply, one multiplier bit a cycle
        acc_r <= acc_nxt;
        ma_r <= addm(ma_r, ma_r, n_r);
        mb_r <= mb_r >> 1;
        if (mb_r == '0 || cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          case (msel_r)
            MSEL_R_B: r_r <= acc_nxt;
            MSEL_B_B: b_r <= acc_nxt;
            default:  x_r <= acc_nxt;
          endcase
        end
      end
    end else begin
      case (cmd.op)
        OP_SHIFT: begin
          d_r <= d_r >> 1;
          s_r <= s_r + SW'(1);
        end
        OP_DSHIFT: d_r <= d_r >> 1;
        OP_COPY:   x_r <= r_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.busy         = busy_r;
    stat.trivial      = (n_r <= N_BITS'(3)) || !n_r[0];
    stat.trivial_pass = (n_r == N_BITS'(2)) || (n_r == N_BITS'(3));
    stat.d_odd        = d_r[0];
    stat.e_zero       = (d_r == '0);
    stat.e_lsb        = d_r[0];
    stat.s_le1        = (s_r <= SW'(1));
    stat.x_one        = (x_r == N_BITS'(1));
    stat.x_nm1        = (x_r == nm1);
  end
endmodule
`default_nettype wire

// ----- rtl/mrr_ctrl.sv -----
`default_nettype none
module mrr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic               out_free,
  input  wire mrr_pkg::mrr_stat_t stat,
  output mrr_pkg::mrr_cmd_t       cmd,
  output logic                    idle,
  output logic                    done,
  output logic                    pass
);
  import mrr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_STRIP = 11'b00000000100,
    S_RED   = 11'b00000001000,
    S_BIT   = 11'b00000010000,
    S_MULW  = 11'b00000100000,
    S_SQW   = 11'b00001000000,
    S_COPY  = 11'b00010000000,
    S_EVAL  = 11'b00100000000,
    S_LOOPW = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   first_r, first_nxt;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    first_nxt = first_r;
    cmd       = '{op: OP_NONE, msel: MSEL_R_B, start: 1'b0};
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.trivial) begin
          pass_nxt = stat.trivial_pass;
          state_nxt = S_DONE;
        end else state_nxt = S_STRIP;
      end
      S_STRIP: begin
        if (stat.d_odd) begin
          cmd = '{op: OP_REDUCE, msel: MSEL_R_B, start: 1'b1};
          state_nxt = S_RED;
        end else begin
          cmd.op = OP_SHIFT;
        end
      end
      S_RED: if (!stat.busy) state_nxt = S_BIT;
      S_BIT: begin
        // d is consumed bit by bit while squaring the base
        if (stat.e_zero) state_nxt = S_COPY;
        else if (stat.e_lsb) begin
          cmd = '{op: OP_MUL, msel: MSEL_R_B, start: 1'b1};
          state_nxt = S_MULW;
        end else begin
          cmd = '{op: OP_MUL, msel: MSEL_B_B, start: 1'b1};
          state_nxt = S_SQW;
        end
      end
      S_MULW: if (!stat.busy) begin
        cmd = '{op: OP_MUL, msel: MSEL_B_B, start: 1'b1};
        state_nxt = S_SQW;
      end
      S_SQW: if (!stat.busy) begin
        cmd.op = OP_DSHIFT;
        state_nxt = S_BIT;
      end
      S_COPY: begin
        cmd.op = OP_COPY;
        first_nxt = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // x == 1 only counts before the first squaring
        if (stat.x_nm1 || (first_r && stat.x_one)) begin
          pass_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          pass_nxt = 1'b0;
          first_nxt = 1'b0;
          state_nxt = S_DONE;
          if (!stat.s_le1) begin
            cmd = '{op: OP_MUL, msel: MSEL_X_X, start: 1'b1};
            state_nxt = S_LOOPW;
          end
        end
      end
      S_LOOPW: if (!stat.busy) state_nxt = S_EVAL;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      first_r <= first_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign pass = pass_r;
endmodule
`default_nettype wire
